// ----- rtl/tlik_pkg.sv -----
// shared types, constants and tables of the two-link leg inverse kinematics block
`timescale 1ns / 1ps
`default_nettype none
package tlik_pkg;

   localparam int FRAC_BITS_DEF     = 12;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int FIELD_W           = 16;
   localparam int STATUS_W          = 2;

   // angles are Q6.30 radians, wide enough for 2pi and its sums
   localparam int ANG_W    = 36;
   localparam int ANG_FRAC = 30;

   localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;

   localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_REACH = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HIP_NEGATIVE = 2'd2;

   typedef struct packed {
      logic signed [FIELD_W-1:0] hip_angle;
      logic signed [FIELD_W-1:0] knee_angle;
      logic [STATUS_W-1:0]       status;
   } rsp_payload_type;

   // atan(2^-i) in Q6.30
   function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned idx);
      case (idx)
         0:       return 36'sd843314857;
         1:       return 36'sd497837830;
         2:       return 36'sd263043837;
         3:       return 36'sd133525159;
         4:       return 36'sd67021688;
         5:       return 36'sd33543515;
         6:       return 36'sd16775851;
         7:       return 36'sd8388438;
         8:       return 36'sd4194283;
         9:       return 36'sd2097149;
         10:      return 36'sd1048576;
         11:      return 36'sd524288;
         12:      return 36'sd262144;
         13:      return 36'sd131072;
         14:      return 36'sd65536;
         15:      return 36'sd32768;
         16:      return 36'sd16384;
         17:      return 36'sd8192;
         18:      return 36'sd4096;
         19:      return 36'sd2048;
         20:      return 36'sd1024;
         21:      return 36'sd512;
         22:      return 36'sd256;
         23:      return 36'sd128;
         default: return '0;
      endcase
   endfunction

endpackage
`default_nettype wire

// ----- rtl/tlik_req_if.sv -----
// target channel carrying one foot position per transfer
`timescale 1ns / 1ps
`default_nettype none
interface tlik_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [tlik_pkg::FIELD_W-1:0]    target_x;
   logic signed [tlik_pkg::FIELD_W-1:0]    target_y;

   modport source (output valid, output target_x, output target_y, input ready);
   modport sink   (input valid, input target_x, input target_y, output ready);
endinterface
`default_nettype wire

// ----- rtl/tlik_rsp_if.sv -----
// result channel carrying hip angle, knee angle and status per transfer
`timescale 1ns / 1ps
`default_nettype none
interface tlik_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [tlik_pkg::FIELD_W-1:0]    hip_angle;
   logic signed [tlik_pkg::FIELD_W-1:0]    knee_angle;
   logic [tlik_pkg::STATUS_W-1:0]          status;

   modport source (output valid, output hip_angle, output knee_angle, output status,
                   input ready);
   modport sink   (input valid, input hip_angle, input knee_angle, input status,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/tlik_isqrt.sv -----
// pipelined two-lane floor square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module tlik_isqrt #(
   parameter int RAD_W = 32,
   parameter int SB_W  = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [RAD_W-1:0]      in_rad_a,
   input  wire logic [RAD_W-1:0]      in_rad_b,
   input  wire logic [SB_W-1:0]       in_sb,
   output logic                       out_valid,
   output logic [RAD_W/2-1:0]         out_root_a,
   output logic [RAD_W/2-1:0]         out_root_b,
   output logic [SB_W-1:0]            out_sb
);
   localparam int RT_W  = RAD_W / 2;
   localparam int REM_W = RT_W + 3;

   function automatic logic [REM_W+RT_W-1:0] sq_step(input logic [REM_W-1:0] rem,
                                                      input logic [RT_W-1:0] q,
                                                      input logic [1:0] pair);
      logic [REM_W-1:0] r2;
      logic [REM_W-1:0] t;
      r2 = {rem[REM_W-3:0], pair};
      t  = {1'b0, q, 2'b01};
      if (r2 >= t) begin
         return {r2 - t, q[RT_W-2:0], 1'b1};
      end
      return {r2, q[RT_W-2:0], 1'b0};
   endfunction

   logic             valid_ff [RT_W];
   logic [RAD_W-1:0] rad_a_ff [RT_W];
   logic [RAD_W-1:0] rad_b_ff [RT_W];
   logic [REM_W-1:0] rem_a_ff [RT_W];
   logic [REM_W-1:0] rem_b_ff [RT_W];
   logic [RT_W-1:0]  q_a_ff   [RT_W];
   logic [RT_W-1:0]  q_b_ff   [RT_W];
   logic [SB_W-1:0]  sb_ff    [RT_W];

   for (genvar k = 0; k < RT_W; k++) begin : g_stage
      logic             cur_valid;
      logic [RAD_W-1:0] cur_rad_a, cur_rad_b;
      logic [REM_W-1:0] cur_rem_a, cur_rem_b;
      logic [RT_W-1:0]  cur_q_a, cur_q_b;
      logic [SB_W-1:0]  cur_sb;
      logic [REM_W+RT_W-1:0] step_a_in, step_b_in;

      if (k == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_rad_a = in_rad_a;
         assign cur_rad_b = in_rad_b;
         assign cur_rem_a = '0;
         assign cur_rem_b = '0;
         assign cur_q_a   = '0;
         assign cur_q_b   = '0;
         assign cur_sb    = in_sb;
      end else begin : g_next
         assign cur_valid = valid_ff[k-1];
         assign cur_rad_a = rad_a_ff[k-1];
         assign cur_rad_b = rad_b_ff[k-1];
         assign cur_rem_a = rem_a_ff[k-1];
         assign cur_rem_b = rem_b_ff[k-1];
         assign cur_q_a   = q_a_ff[k-1];
         assign cur_q_b   = q_b_ff[k-1];
         assign cur_sb    = sb_ff[k-1];
      end

      assign step_a_in = sq_step(cur_rem_a, cur_q_a, cur_rad_a[RAD_W-1 -: 2]);
      assign step_b_in = sq_step(cur_rem_b, cur_q_b, cur_rad_b[RAD_W-1 -: 2]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_a_ff[k] <= {cur_rad_a[RAD_W-3:0], 2'b00};
            rad_b_ff[k] <= {cur_rad_b[RAD_W-3:0], 2'b00};
            rem_a_ff[k] <= step_a_in[REM_W+RT_W-1:RT_W];
            rem_b_ff[k] <= step_b_in[REM_W+RT_W-1:RT_W];
            q_a_ff[k]   <= step_a_in[RT_W-1:0];
            q_b_ff[k]   <= step_b_in[RT_W-1:0];
            sb_ff[k]    <= cur_sb;
         end
      end
   end

   assign out_valid  = valid_ff[RT_W-1];
   assign out_root_a = q_a_ff[RT_W-1];
   assign out_root_b = q_b_ff[RT_W-1];
   assign out_sb     = sb_ff[RT_W-1];
endmodule
`default_nettype wire

// ----- rtl/tlik_cordic.sv -----
// pipelined two-lane vectoring cordic atan2, a quadrant-fold stage then one iteration per stage
`timescale 1ns / 1ps
`default_nettype none
module tlik_cordic #(
   parameter int VEC_W  = 34,
   parameter int STAGES = 16,
   parameter int SB_W   = 1
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire logic                                in_valid,
   input  wire logic signed [VEC_W-1:0]             in_ay,
   input  wire logic signed [VEC_W-1:0]             in_ax,
   input  wire logic signed [VEC_W-1:0]             in_by,
   input  wire logic signed [VEC_W-1:0]             in_bx,
   input  wire logic [SB_W-1:0]                     in_sb,
   output logic                                     out_valid,
   output logic signed [tlik_pkg::ANG_W-1:0]        out_za,
   output logic signed [tlik_pkg::ANG_W-1:0]        out_zb,
   output logic [SB_W-1:0]                          out_sb
);
   localparam int XW = VEC_W + 2;
   localparam int ZW = tlik_pkg::ANG_W;
   localparam int LW = 2 * XW + ZW;

   // quadrant fold so that x is not negative
   function automatic logic [LW-1:0] fold(input logic signed [VEC_W-1:0] y,
                                          input logic signed [VEC_W-1:0] x);
      logic signed [XW-1:0] xe;
      logic signed [XW-1:0] ye;
      xe = XW'(x);
      ye = XW'(y);
      if (!x[VEC_W-1]) begin
         return {xe, ye, {ZW{1'b0}}};
      end
      if (!y[VEC_W-1]) begin
         return {ye, -xe, tlik_pkg::HALF_PI_Q30};
      end
      return {-ye, xe, -tlik_pkg::HALF_PI_Q30};
   endfunction

   function automatic logic [LW-1:0] rot(input logic [LW-1:0] v, input int unsigned i);
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      x  = v[LW-1 -: XW];
      y  = v[ZW +: XW];
      z  = v[ZW-1:0];
      xs = x >>> i;
      ys = y >>> i;
      if (!y[XW-1] && (y != '0)) begin
         return {x + ys, y - xs, z + tlik_pkg::atan_entry(i)};
      end
      return {x - ys, y + xs, z - tlik_pkg::atan_entry(i)};
   endfunction

   logic            valid_ff [STAGES+1];
   logic [LW-1:0]   lane_a_ff [STAGES+1];
   logic [LW-1:0]   lane_b_ff [STAGES+1];
   logic [SB_W-1:0] sb_ff [STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_a_ff[0] <= fold(in_ay, in_ax);
         lane_b_ff[0] <= fold(in_by, in_bx);
         sb_ff[0]     <= in_sb;
      end
   end

   for (genvar k = 1; k <= STAGES; k++) begin : g_iter
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            lane_a_ff[k] <= rot(lane_a_ff[k-1], k - 1);
            lane_b_ff[k] <= rot(lane_b_ff[k-1], k - 1);
            sb_ff[k]     <= sb_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_za    = lane_a_ff[STAGES][ZW-1:0];
   assign out_zb    = lane_b_ff[STAGES][ZW-1:0];
   assign out_sb    = sb_ff[STAGES];
endmodule
`default_nettype wire

// ----- rtl/two_link_leg_inverse_kinematics.sv -----
// path: target capture, squares, distance, square-root pipe, products, vectors, cordic pipe,
// hip and knee stages and the output register lie between input transfer and result valid
// throughput: one target per cycle while the skid stage is empty; the whole pipe stalls while it is full
// a two-entry output register and skid stage hold results while the sink stalls
// reset: synchronous active high, clears all valid bits and knee_direction to 0
`timescale 1ns / 1ps
`default_nettype none
module two_link_leg_inverse_kinematics #(
   parameter int FRAC_BITS     = tlik_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data,
   tlik_req_if.sink     req_ch,
   tlik_rsp_if.source   rsp_ch
);
   localparam int FW     = tlik_pkg::FIELD_W;
   localparam int ZW     = tlik_pkg::ANG_W;
   // radicand width: fits x*x + y*y and 4 in Q.2F, kept even
   localparam int SQRT_W = (2 * FRAC_BITS + 4 > 32) ? (2 * FRAC_BITS + 4) : 32;
   localparam int RW     = SQRT_W / 2;
   localparam int PW     = FW + RW + 1;
   localparam int VW     = PW + 1;
   localparam int SH     = tlik_pkg::ANG_FRAC - FRAC_BITS;
   localparam int SB1_W  = 2 * FW + 3;
   localparam logic [SQRT_W-1:0] FOUR = SQRT_W'(1) << (2 * FRAC_BITS + 2);
   localparam logic [ZW-1:0]     RND_HALF = ZW'(1) << (SH - 1);

   // knee direction register
   logic dir_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= 1'b0;
      end else if (csr_write_enable) begin
         dir_ff <= csr_write_data;
      end
   end

   // the whole pipe moves unless the skid stage is holding a result
   logic en;
   logic skid_full_ff;
   assign en           = !skid_full_ff;
   assign req_ch.ready = en;

   // stage 1: capture the target
   logic                 s1_valid_ff;
   logic signed [FW-1:0] s1_x_ff, s1_y_ff;
   logic                 s1_dir_ff;
   // stage 2: squares
   logic                   s2_valid_ff;
   logic signed [2*FW-1:0] s2_xx_ff, s2_yy_ff;
   logic signed [FW-1:0]   s2_x_ff, s2_y_ff;
   logic                   s2_dir_ff;
   // stage 3: distance squared and its complement to 4
   logic                 s3_valid_ff;
   logic [SQRT_W-1:0]    s3_d2_ff, s3_h2_ff;
   logic [SB1_W-1:0]     s3_sb_ff;
   logic [SQRT_W-1:0]    d2_in;

   assign d2_in = SQRT_W'($unsigned(s2_xx_ff)) + SQRT_W'($unsigned(s2_yy_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_ch.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff   <= req_ch.target_x;
         s1_y_ff   <= req_ch.target_y;
         s1_dir_ff <= dir_ff;
         s2_xx_ff  <= s1_x_ff * s1_x_ff;
         s2_yy_ff  <= s1_y_ff * s1_y_ff;
         s2_x_ff   <= s1_x_ff;
         s2_y_ff   <= s1_y_ff;
         s2_dir_ff <= s1_dir_ff;
         s3_d2_ff  <= d2_in;
         s3_h2_ff  <= FOUR - d2_in;
         // sideband: x, y, direction, target at origin, out of reach
         s3_sb_ff  <= {s2_x_ff, s2_y_ff, s2_dir_ff, (d2_in == '0), (d2_in > FOUR)};
      end
   end

   // square roots of the distance and of the knee offset
   logic              sq_valid;
   logic [RW-1:0]     sq_d, sq_h;
   logic [SB1_W-1:0]  sq_sb;

   tlik_isqrt #(.RAD_W(SQRT_W), .SB_W(SB1_W)) u_isqrt (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (s3_valid_ff),
      .in_rad_a   (s3_d2_ff),
      .in_rad_b   (s3_h2_ff),
      .in_sb      (s3_sb_ff),
      .out_valid  (sq_valid),
      .out_root_a (sq_d),
      .out_root_b (sq_h),
      .out_sb     (sq_sb)
   );

   logic signed [FW-1:0] sq_x, sq_y;
   assign sq_x = sq_sb[SB1_W-1 -: FW];
   assign sq_y = sq_sb[SB1_W-FW-1 -: FW];

   // stage 4: the four products
   logic                 s4_valid_ff;
   logic signed [PW-1:0] s4_xd_ff, s4_yd_ff, s4_xh_ff, s4_yh_ff;
   logic [2:0]           s4_sb_ff;
   // stage 5: knee and lower-link vectors, both scaled by 2D
   logic                 s5_valid_ff;
   logic signed [VW-1:0] s5_kx_ff, s5_ky_ff, s5_fx_ff, s5_fy_ff;
   logic [1:0]           s5_sb_ff;

   logic signed [PW-1:0] dd_s, hh_s;
   assign dd_s = PW'($signed({1'b0, sq_d}));
   assign hh_s = PW'($signed({1'b0, sq_h}));

   logic signed [VW-1:0] xd_e, yd_e, xh_e, yh_e;
   logic                 s4_dir;
   assign xd_e   = VW'(s4_xd_ff);
   assign yd_e   = VW'(s4_yd_ff);
   assign xh_e   = VW'(s4_xh_ff);
   assign yh_e   = VW'(s4_yh_ff);
   assign s4_dir = s4_sb_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= sq_valid;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_xd_ff <= PW'(sq_x) * dd_s;
         s4_yd_ff <= PW'(sq_y) * dd_s;
         s4_xh_ff <= PW'(sq_x) * hh_s;
         s4_yh_ff <= PW'(sq_y) * hh_s;
         s4_sb_ff <= sq_sb[2:0];
         // direction 0 takes the first meeting point, 1 the mirrored one
         s5_kx_ff <= s4_dir ? (xd_e - yh_e) : (xd_e + yh_e);
         s5_ky_ff <= s4_dir ? (yd_e + xh_e) : (yd_e - xh_e);
         s5_fx_ff <= s4_dir ? (xd_e + yh_e) : (xd_e - yh_e);
         s5_fy_ff <= s4_dir ? (yd_e - xh_e) : (yd_e + xh_e);
         s5_sb_ff <= s4_sb_ff[1:0];
      end
   end

   // angles of the knee vector (lane a) and lower-link vector (lane b)
   logic                 co_valid;
   logic signed [ZW-1:0] co_alpha, co_fz;
   logic [1:0]           co_sb;

   tlik_cordic #(.VEC_W(VW), .STAGES(CORDIC_STAGES), .SB_W(2)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_valid_ff),
      .in_ay     (s5_ky_ff),
      .in_ax     (s5_kx_ff),
      .in_by     (s5_fy_ff),
      .in_bx     (s5_fx_ff),
      .in_sb     (s5_sb_ff),
      .out_valid (co_valid),
      .out_za    (co_alpha),
      .out_zb    (co_fz),
      .out_sb    (co_sb)
   );

   // stage e1: hip offset, raw knee difference, hip sign
   logic                 e1_valid_ff;
   logic signed [ZW-1:0] e1_hip_ff, e1_beta_ff;
   logic                 e1_neg_ff, e1_zero_ff, e1_oor_ff;
   // stage e2: knee wrap, special cases, status
   logic                 e2_valid_ff;
   logic signed [ZW-1:0] e2_hip_ff, e2_knee_ff;
   logic [tlik_pkg::STATUS_W-1:0] e2_status_ff;

   logic signed [ZW-1:0] beta_wrap;
   logic [tlik_pkg::STATUS_W-1:0] status_in;

   assign beta_wrap = (e1_beta_ff < -tlik_pkg::PI_Q30) ? (e1_beta_ff + tlik_pkg::TWO_PI_Q30)
                                                        : e1_beta_ff;

   always_comb begin
      status_in = tlik_pkg::STATUS_OK;
      if (e1_zero_ff) begin
         status_in = tlik_pkg::STATUS_OK;
      end else if (e1_oor_ff) begin
         status_in = tlik_pkg::STATUS_OUT_OF_REACH;
      end else if (e1_neg_ff) begin
         status_in = tlik_pkg::STATUS_HIP_NEGATIVE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
      end else if (en) begin
         e1_valid_ff <= co_valid;
         e2_valid_ff <= e1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_hip_ff    <= co_alpha - tlik_pkg::HALF_PI_Q30;
         e1_beta_ff   <= co_fz - co_alpha;
         e1_neg_ff    <= co_alpha[ZW-1];
         e1_zero_ff   <= co_sb[1];
         e1_oor_ff    <= co_sb[0];
         // target at the origin: hip 0, knee pi
         e2_hip_ff    <= e1_zero_ff ? '0 : e1_hip_ff;
         e2_knee_ff   <= e1_zero_ff ? tlik_pkg::PI_Q30 : beta_wrap;
         e2_status_ff <= status_in;
      end
   end

   // round half away from zero to Q.FRAC_BITS, then saturate to 16 bits
   function automatic logic signed [FW-1:0] to_out(input logic signed [ZW-1:0] a);
      logic [ZW-1:0] mag;
      logic [ZW-1:0] r;
      mag = a[ZW-1] ? ZW'(-a) : ZW'(a);
      r   = (mag + RND_HALF) >> SH;
      if (a[ZW-1]) begin
         if (r > ZW'(32768)) begin
            return {1'b1, {(FW-1){1'b0}}};
         end
         return FW'(-r);
      end
      if (r > ZW'(32767)) begin
         return {1'b0, {(FW-1){1'b1}}};
      end
      return FW'(r);
   endfunction

   tlik_pkg::rsp_payload_type p_data;
   always_comb begin
      p_data.status     = e2_status_ff;
      p_data.hip_angle  = '0;
      p_data.knee_angle = '0;
      // both error cases report zero angles
      if (e2_status_ff == tlik_pkg::STATUS_OK) begin
         p_data.hip_angle  = to_out(e2_hip_ff);
         p_data.knee_angle = to_out(e2_knee_ff);
      end
   end

   // output register plus skid stage
   tlik_pkg::rsp_payload_type out_ff, out_in, skid_ff, skid_in;
   logic out_valid_ff, out_valid_in, skid_full_in;
   logic transfer;

   assign transfer = out_valid_ff && rsp_ch.ready;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      skid_in      = skid_ff;
      skid_full_in = skid_full_ff;
      if (skid_full_ff) begin
         if (transfer) begin
            out_in       = skid_ff;
            skid_full_in = 1'b0;
         end
      end else if (e2_valid_ff) begin
         if (out_valid_ff && !rsp_ch.ready) begin
            skid_in      = p_data;
            skid_full_in = 1'b1;
         end else begin
            out_in       = p_data;
            out_valid_in = 1'b1;
         end
      end else if (transfer) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.hip_angle  = out_ff.hip_angle;
   assign rsp_ch.knee_angle = out_ff.knee_angle;
   assign rsp_ch.status     = out_ff.status;

   // a held result in the skid stage always has one ahead of it
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_valid_ff)
      else $error("skid holds a result with no result in the output register");

   // the skid stage fills only on a stalled output
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(out_valid_ff && !rsp_ch.ready))
      else $error("skid filled while the output was free");

   // error results carry zero angles
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.status == tlik_pkg::STATUS_OUT_OF_REACH ||
                        out_ff.status == tlik_pkg::STATUS_HIP_NEGATIVE))
      |-> (out_ff.hip_angle == '0 && out_ff.knee_angle == '0))
      else $error("error result with nonzero angle");

   // status is always one of the three defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.status == tlik_pkg::STATUS_OK ||
                        out_ff.status == tlik_pkg::STATUS_OUT_OF_REACH ||
                        out_ff.status == tlik_pkg::STATUS_HIP_NEGATIVE))
      else $error("undefined status code");
endmodule
`default_nettype wire
